@@ rtl/thring_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package thring_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int TS_W  = 48;
  localparam int PL_W  = 64;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RETENTION    = 1'b1;

  localparam logic [CFG_W-1:0] MIN_INTERVAL_RST = 32'd1000;
  localparam logic [CFG_W-1:0] RETENTION_RST    = 32'd3600000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHECK,
    ST_EVICT,
    ST_WRITE,
    ST_STREAM
  } state_t;

  typedef enum logic [1:0] {
    RD_NEWEST,
    RD_OLDEST,
    RD_NEXT_OLDEST,
    RD_STREAM_NEXT
  } rd_sel_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_REJECT,
    EMIT_ACCEPT,
    EMIT_EMPTY,
    EMIT_ENTRY
  } emit_t;

  typedef struct packed {
    logic    latch;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    pop;
    logic    write;
    logic    stream_clr;
    logic    stream_inc;
    emit_t   emit;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic ts_zero;
    logic count_zero;
    logic newest_ok;
    logic evict_hit;
    logic stream_last;
  } stat_t;

  // Ring position base + offset, wrapped at DEPTH; offset never exceeds DEPTH.
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] offset);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, offset};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/thring_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module thring_dp import thring_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              action,
  input  wire logic [TS_W-1:0]   sample_time,
  input  wire logic [PL_W-1:0]   sample_value,
  input  wire logic              cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  output logic                   done,
  output logic                   accepted,
  output logic                   entry_valid,
  output logic [TS_W-1:0]        entry_time,
  output logic [PL_W-1:0]        entry_payload,
  output logic                   last
);

  logic [TS_W-1:0]  stamp_mem [DEPTH];
  logic [PL_W-1:0]  payload_mem [DEPTH];

  logic [CFG_W-1:0] min_interval;
  logic [CFG_W-1:0] retention;

  logic             action_q;
  logic [TS_W-1:0]  ts_q;
  logic [PL_W-1:0]  value_q;
  logic [TS_W-1:0]  cutoff;

  logic [IDX_W-1:0] oldest;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] stream_pos;

  logic [TS_W-1:0]  rd_stamp;
  logic [PL_W-1:0]  rd_payload;

  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_slot;
  logic [IDX_W-1:0] oldest_plus1;
  logic             full;

  assign oldest_plus1 = ring_pos(oldest, CNT_W'(1));
  assign full         = (count == CNT_W'(DEPTH));
  assign wr_slot      = full ? oldest : ring_pos(oldest, count);

  always_comb begin
    unique case (cmd.rd_sel)
      RD_NEWEST:      rd_addr = ring_pos(oldest, count - CNT_W'(1));
      RD_OLDEST:      rd_addr = oldest;
      RD_NEXT_OLDEST: rd_addr = oldest_plus1;
      RD_STREAM_NEXT: rd_addr = ring_pos(oldest, stream_pos + CNT_W'(1));
      default:        rd_addr = oldest;
    endcase
  end

  // Status toward the controller
  always_comb begin
    stat.is_read     = (action_q == ACT_READ);
    stat.ts_zero     = (ts_q == '0);
    stat.count_zero  = (count == '0);
    stat.newest_ok   = (({1'b0, rd_stamp} + (TS_W + 1)'(min_interval)) < {1'b0, ts_q});
    stat.evict_hit   = (count != '0) && (rd_stamp < cutoff);
    stat.stream_last = ({1'b0, stream_pos} + (CNT_W + 1)'(1)) == {1'b0, count};
  end

  // Storage
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      stamp_mem[wr_slot]   <= ts_q;
      payload_mem[wr_slot] <= value_q;
    end
    if (cmd.rd_en) begin
      rd_stamp   <= stamp_mem[rd_addr];
      rd_payload <= payload_mem[rd_addr];
    end
  end

  // Input capture and eviction cutoff
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      action_q <= action;
      ts_q     <= sample_time;
      value_q  <= sample_value;
    end
    if (ts_q > TS_W'(retention)) begin
      cutoff <= ts_q - TS_W'(retention);
    end else begin
      cutoff <= '0;
    end
  end

  // Ring pointers, stream position, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest       <= '0;
      count        <= '0;
      stream_pos   <= '0;
      min_interval <= MIN_INTERVAL_RST;
      retention    <= RETENTION_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_INTERVAL: min_interval <= cfg_data;
          REG_RETENTION:    retention    <= cfg_data;
          default:          ;
        endcase
      end
      if (cmd.pop) begin
        oldest <= oldest_plus1;
        count  <= count - CNT_W'(1);
      end else if (cmd.write) begin
        if (full) begin
          oldest <= oldest_plus1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.stream_clr) begin
        stream_pos <= '0;
      end else if (cmd.stream_inc) begin
        stream_pos <= stream_pos + CNT_W'(1);
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    accepted    <= (cmd.emit == EMIT_ACCEPT);
    entry_valid <= (cmd.emit == EMIT_ENTRY);
    if (cmd.emit == EMIT_ENTRY) begin
      entry_time    <= rd_stamp;
      entry_payload <= rd_payload;
      last          <= stat.stream_last;
    end else begin
      entry_time    <= '0;
      entry_payload <= '0;
      last          <= 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ rtl/thring_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module thring_ctrl import thring_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd.latch      = 1'b0;
    cmd.rd_en      = 1'b0;
    cmd.rd_sel     = RD_OLDEST;
    cmd.pop        = 1'b0;
    cmd.write      = 1'b0;
    cmd.stream_clr = 1'b0;
    cmd.stream_inc = 1'b0;
    cmd.emit       = EMIT_NONE;
    busy           = (state != ST_IDLE);

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.is_read) begin
          if (stat.count_zero) begin
            cmd.emit   = EMIT_EMPTY;
            state_next = ST_IDLE;
          end else begin
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = RD_OLDEST;
            cmd.stream_clr = 1'b1;
            state_next     = ST_STREAM;
          end
        end else if (stat.ts_zero) begin
          cmd.emit   = EMIT_REJECT;
          state_next = ST_IDLE;
        end else if (stat.count_zero) begin
          state_next = ST_WRITE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEWEST;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!stat.newest_ok) begin
          cmd.emit   = EMIT_REJECT;
          state_next = ST_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_OLDEST;
          state_next = ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (stat.evict_hit) begin
          cmd.pop    = 1'b1;
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_NEXT_OLDEST;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write  = 1'b1;
        cmd.emit   = EMIT_ACCEPT;
        state_next = ST_IDLE;
      end
      ST_STREAM: begin
        cmd.emit = EMIT_ENTRY;
        if (stat.stream_last) begin
          state_next = ST_IDLE;
        end else begin
          cmd.stream_inc = 1'b1;
          cmd.rd_en      = 1'b1;
          cmd.rd_sel     = RD_STREAM_NEXT;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/timestamped_history_ring.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One series of a timestamped history: a ring of DEPTH (64) entries, each a
// 48-bit millisecond timestamp and a 64-bit payload. Pulse start while busy
// is low to hand over one item. A record (action 0) is rejected when the
// timestamp is zero or, with the ring not empty, when the newest stamp plus
// min_interval_ms is not below the new timestamp; otherwise entries older
// than timestamp minus retention_ms are dropped from the oldest end, one per
// cycle, and the sample is appended (overwriting the oldest when full). Its
// single result comes back with accepted and last set as needed. A read
// (action 1) streams every stored entry oldest first, one per cycle, with
// last on the final one; an empty ring gives one result with entry_valid 0.
// Results are shown for exactly one cycle under done and the receiver has
// no way to stall them, so sample them on that cycle. Eviction and
// readout walk the entry memory through its single registered read port,
// one entry per cycle. busy falls with the cycle the last result is
// produced, so a new start can be issued while that result is on the
// ports. Configuration writes (cfg_we, cfg_index 0 = min_interval_ms,
// 1 = retention_ms) take effect at once and belong to idle periods only.
module timestamped_history_ring import thring_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // item transfer
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 action,
  input  wire logic [TS_W-1:0]      sample_time,
  input  wire logic [PL_W-1:0]      sample_value,
  // configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // result transfer
  output logic                      done,
  output logic                      accepted,
  output logic                      entry_valid,
  output logic [TS_W-1:0]           entry_time,
  output logic [PL_W-1:0]           entry_payload,
  output logic                      last
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: decides reject, eviction walk, write, or readout
  thring_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Entry memory, ring pointers, comparators and result registers
  thring_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .action        (action),
    .sample_time   (sample_time),
    .sample_value  (sample_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .done          (done),
    .accepted      (accepted),
    .entry_valid   (entry_valid),
    .entry_time    (entry_time),
    .entry_payload (entry_payload),
    .last          (last)
  );

  // An accepted record is a single, final result with no entry attached.
  a_accept_alone: assert property (@(posedge clk) disable iff (rst)
    done && accepted |-> !entry_valid && last)
    else $error("accepted record result carries an entry or lacks last");

  // A transfer in always occupies the block for at least the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("item taken but block not busy");

  // Readout never pauses between entries of one stream.
  a_stream_gapless: assert property (@(posedge clk) disable iff (rst)
    done && entry_valid && !last |=> done && entry_valid)
    else $error("gap inside entry readout");

  // The sequencer never stores and evicts in the same cycle.
  a_write_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.write && cmd.pop))
    else $error("write and pop issued together");

endmodule
`default_nettype wire
